// File: rtl/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst, prop)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/pts_pkg.sv
// types, constants and helpers of the pan/tilt slew controller
package pts_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINK_TIMEOUT  = 3'd0,
      REG_LASER_PULSE   = 3'd1,
      REG_SLEW_INTERVAL = 3'd2,
      REG_PAN_LIMIT     = 3'd3,
      REG_TILT_LIMIT    = 3'd4,
      REG_BLINK_LASER   = 3'd5,
      REG_BLINK_NOLINK  = 3'd6,
      REG_BLINK_TRIGGER = 3'd7
   } reg_index_type;

   localparam logic       KIND_TICK    = 1'b0;
   localparam logic       KIND_COMMAND = 1'b1;

   localparam logic [7:0] TRIGGER_OFF  = 8'd0;
   localparam logic [7:0] TRIGGER_ON   = 8'd1;
   localparam logic [7:0] TRIGGER_FIRE = 8'd2;

   localparam logic [15:0] RST_LINK_TIMEOUT  = 16'd2000;
   localparam logic [15:0] RST_LASER_PULSE   = 16'd2000;
   localparam logic [7:0]  RST_SLEW_INTERVAL = 8'd20;
   localparam logic [8:0]  RST_PAN_LIMIT     = 9'd270;
   localparam logic [7:0]  RST_TILT_LIMIT    = 8'd180;
   localparam logic [15:0] RST_BLINK_LASER   = 16'd100;
   localparam logic [15:0] RST_BLINK_NOLINK  = 16'd1000;
   localparam logic [15:0] RST_BLINK_TRIGGER = 16'd200;

   localparam logic [8:0] PAN_HOME  = 9'd135;
   localparam logic [7:0] TILT_HOME = 8'd90;

   typedef struct packed {
      logic              kind;
      logic signed [15:0] pan_request;
      logic signed [15:0] tilt_request;
      logic [7:0]        trigger_code;
   } req_type;

   typedef struct packed {
      logic [8:0] pan_now;
      logic [7:0] tilt_now;
      logic       trigger_out;
      logic       laser_out;
      logic       led_out;
      logic       link_up;
   } rsp_type;

   typedef struct packed {
      logic [15:0] link_timeout_ms;
      logic [15:0] laser_pulse_ms;
      logic [7:0]  slew_interval_ms;
      logic [8:0]  pan_limit;
      logic [7:0]  tilt_limit;
      logic [15:0] blink_laser_ms;
      logic [15:0] blink_nolink_ms;
      logic [15:0] blink_trigger_ms;
   } cfg_type;

   // negative words clamp to zero, large ones to the limit
   function automatic logic [8:0] clamp_angle(input logic signed [15:0] request,
                                              input logic [8:0] limit);
      logic [15:0] word;
      word = request;
      if (word[15]) begin
         return 9'd0;
      end else if (word > {7'd0, limit}) begin
         return limit;
      end else begin
         return word[8:0];
      end
   endfunction

endpackage

// File: rtl/pts_csr.sv
// configuration register bank of the pan/tilt slew controller
module pts_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [pts_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  logic [pts_pkg::CSR_DATA_W-1:0]     wr_data,
   output pts_pkg::cfg_type                   cfg
);

   pts_pkg::cfg_type cfg_ff;
   pts_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (pts_pkg::reg_index_type'(wr_index))
            pts_pkg::REG_LINK_TIMEOUT:  cfg_in.link_timeout_ms  = wr_data;
            pts_pkg::REG_LASER_PULSE:   cfg_in.laser_pulse_ms   = wr_data;
            pts_pkg::REG_SLEW_INTERVAL: cfg_in.slew_interval_ms = wr_data[7:0];
            pts_pkg::REG_PAN_LIMIT:     cfg_in.pan_limit        = wr_data[8:0];
            pts_pkg::REG_TILT_LIMIT:    cfg_in.tilt_limit       = wr_data[7:0];
            pts_pkg::REG_BLINK_LASER:   cfg_in.blink_laser_ms   = wr_data;
            pts_pkg::REG_BLINK_NOLINK:  cfg_in.blink_nolink_ms  = wr_data;
            pts_pkg::REG_BLINK_TRIGGER: cfg_in.blink_trigger_ms = wr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_timeout_ms  <= pts_pkg::RST_LINK_TIMEOUT;
         cfg_ff.laser_pulse_ms   <= pts_pkg::RST_LASER_PULSE;
         cfg_ff.slew_interval_ms <= pts_pkg::RST_SLEW_INTERVAL;
         cfg_ff.pan_limit        <= pts_pkg::RST_PAN_LIMIT;
         cfg_ff.tilt_limit       <= pts_pkg::RST_TILT_LIMIT;
         cfg_ff.blink_laser_ms   <= pts_pkg::RST_BLINK_LASER;
         cfg_ff.blink_nolink_ms  <= pts_pkg::RST_BLINK_NOLINK;
         cfg_ff.blink_trigger_ms <= pts_pkg::RST_BLINK_TRIGGER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pan_tilt_slew_controller.sv
// pan/tilt slew controller: command and tick handling, servo slew, laser, status led
//
// Requests arrive on req_valid/req_ready/req_data. Each one is either a one
// millisecond tick or a command frame carrying pan and tilt requests and a
// trigger code. Every accepted request yields exactly one response on
// rsp_valid/rsp_ready/rsp_data with the servo angles and output levels after
// that request has been applied.
// The response is registered and becomes valid in the cycle after acceptance.
// Throughput is one request per clock while rsp_ready is high; the whole update is one combinational
// pass from the state registers into the state and response registers.
// req_ready is high whenever the response register is empty or being taken,
// so a stalled receiver holds the response and blocks only new requests.
// Configuration registers are written on csr_valid/csr_ready/csr_index/csr_data,
// always ready, and should be written while no request is in flight.
// Synchronous reset restores the default configuration, homes both axes to
// 135 and 90 degrees, clears every timer and flag and drives the led steady on.
`include "assert_macros.svh"

module pan_tilt_slew_controller #(
   parameter int TIME_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pts_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pts_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pts_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CMP_W = (TIME_BITS > pts_pkg::CSR_DATA_W) ? TIME_BITS : pts_pkg::CSR_DATA_W;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   pts_pkg::cfg_type cfg;
   pts_pkg::rsp_type rsp_data_ff;
   pts_pkg::rsp_type rsp_data_in;

   logic req_fire;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   logic [8:0] pan_pos_ff,  pan_pos_in;
   logic [7:0] tilt_pos_ff, tilt_pos_in;
   logic [8:0] pan_tgt_ff,  pan_tgt_in;
   logic [7:0] tilt_tgt_ff, tilt_tgt_in;
   logic       trigger_on_ff, trigger_on_in;
   logic       laser_on_ff,   laser_on_in;
   logic       link_on_ff,    link_on_in;
   logic       led_level_ff,  led_level_in;
   logic       led_pin_ff,    led_pin_in;
   logic [TIME_BITS-1:0] laser_el_ff, laser_el_in;
   logic [TIME_BITS-1:0] link_el_ff,  link_el_in;
   logic [TIME_BITS-1:0] slew_el_ff,  slew_el_in;
   logic [TIME_BITS-1:0] blink_el_ff, blink_el_in;

   logic        blink_active;
   logic [15:0] blink_period;
   logic [8:0]  tilt_tgt_wide;

   pts_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign csr_ready = 1'b1;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   assign tilt_tgt_wide = pts_pkg::clamp_angle(req_data.tilt_request, {1'b0, cfg.tilt_limit});

   always_comb begin
      pan_pos_in    = pan_pos_ff;
      tilt_pos_in   = tilt_pos_ff;
      pan_tgt_in    = pan_tgt_ff;
      tilt_tgt_in   = tilt_tgt_ff;
      trigger_on_in = trigger_on_ff;
      laser_on_in   = laser_on_ff;
      link_on_in    = link_on_ff;
      led_level_in  = led_level_ff;
      led_pin_in    = led_pin_ff;
      laser_el_in   = laser_el_ff;
      link_el_in    = link_el_ff;
      slew_el_in    = slew_el_ff;
      blink_el_in   = blink_el_ff;
      blink_active  = 1'b0;
      blink_period  = cfg.blink_trigger_ms;

      if (req_data.kind == pts_pkg::KIND_TICK) begin
         if (laser_el_ff != TIME_MAX) laser_el_in = laser_el_ff + TIME_BITS'(1);
         if (link_el_ff != TIME_MAX)  link_el_in  = link_el_ff + TIME_BITS'(1);
         if (slew_el_ff != TIME_MAX)  slew_el_in  = slew_el_ff + TIME_BITS'(1);
         if (blink_el_ff != TIME_MAX) blink_el_in = blink_el_ff + TIME_BITS'(1);
      end else begin
         pan_tgt_in  = pts_pkg::clamp_angle(req_data.pan_request, cfg.pan_limit);
         tilt_tgt_in = tilt_tgt_wide[7:0];
         link_el_in  = '0;
         link_on_in  = 1'b1;
         if (req_data.trigger_code == pts_pkg::TRIGGER_ON) begin
            trigger_on_in = 1'b1;
         end else if (req_data.trigger_code == pts_pkg::TRIGGER_OFF) begin
            trigger_on_in = 1'b0;
         end
         if (req_data.trigger_code == pts_pkg::TRIGGER_FIRE && !laser_on_ff) begin
            laser_on_in = 1'b1;
            laser_el_in = '0;
         end
      end

      // link watchdog
      if (link_on_in && (CMP_W'(link_el_in) > CMP_W'(cfg.link_timeout_ms))) begin
         link_on_in = 1'b0;
      end

      // one degree per interval toward the target
      if (CMP_W'(slew_el_in) >= CMP_W'(cfg.slew_interval_ms)) begin
         if (pan_pos_ff < pan_tgt_in) begin
            pan_pos_in = pan_pos_ff + 9'd1;
         end else if (pan_pos_ff > pan_tgt_in) begin
            pan_pos_in = pan_pos_ff - 9'd1;
         end
         if (tilt_pos_ff < tilt_tgt_in) begin
            tilt_pos_in = tilt_pos_ff + 8'd1;
         end else if (tilt_pos_ff > tilt_tgt_in) begin
            tilt_pos_in = tilt_pos_ff - 8'd1;
         end
         slew_el_in = '0;
      end

      if (laser_on_in && (CMP_W'(laser_el_in) >= CMP_W'(cfg.laser_pulse_ms))) begin
         laser_on_in = 1'b0;
      end

      // led priority: laser, no link, trigger, else steady
      if (laser_on_in) begin
         blink_active = 1'b1;
         blink_period = cfg.blink_laser_ms;
      end else if (!link_on_in) begin
         blink_active = 1'b1;
         blink_period = cfg.blink_nolink_ms;
      end else if (trigger_on_in) begin
         blink_active = 1'b1;
         blink_period = cfg.blink_trigger_ms;
      end

      if (blink_active) begin
         if (CMP_W'(blink_el_in) >= CMP_W'(blink_period)) begin
            led_level_in = ~led_level_ff;
            led_pin_in   = ~led_level_ff;
            blink_el_in  = '0;
         end
      end else begin
         led_pin_in = 1'b1;
      end

      rsp_data_in.pan_now     = pan_pos_in;
      rsp_data_in.tilt_now    = tilt_pos_in;
      rsp_data_in.trigger_out = trigger_on_in;
      rsp_data_in.laser_out   = laser_on_in;
      rsp_data_in.led_out     = led_pin_in;
      rsp_data_in.link_up     = link_on_in;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pan_pos_ff    <= pts_pkg::PAN_HOME;
         tilt_pos_ff   <= pts_pkg::TILT_HOME;
         pan_tgt_ff    <= pts_pkg::PAN_HOME;
         tilt_tgt_ff   <= pts_pkg::TILT_HOME;
         trigger_on_ff <= 1'b0;
         laser_on_ff   <= 1'b0;
         link_on_ff    <= 1'b0;
         led_level_ff  <= 1'b0;
         led_pin_ff    <= 1'b1;
         laser_el_ff   <= '0;
         link_el_ff    <= '0;
         slew_el_ff    <= '0;
         blink_el_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            pan_pos_ff    <= pan_pos_in;
            tilt_pos_ff   <= tilt_pos_in;
            pan_tgt_ff    <= pan_tgt_in;
            tilt_tgt_ff   <= tilt_tgt_in;
            trigger_on_ff <= trigger_on_in;
            laser_on_ff   <= laser_on_in;
            link_on_ff    <= link_on_in;
            led_level_ff  <= led_level_in;
            led_pin_ff    <= led_pin_in;
            laser_el_ff   <= laser_el_in;
            link_el_ff    <= link_el_in;
            slew_el_ff    <= slew_el_in;
            blink_el_ff   <= blink_el_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // each request moves an axis by at most one degree
   `ASSERT_IMPLIES(a_pan_step, clock, reset, req_fire, ##1 (pan_pos_ff == $past(pan_pos_ff) || pan_pos_ff == $past(pan_pos_ff) + 9'd1 || pan_pos_ff == $past(pan_pos_ff) - 9'd1))
   // a command always leaves the link up
   `ASSERT_IMPLIES(a_cmd_link, clock, reset, req_fire && req_data.kind == pts_pkg::KIND_COMMAND, ##1 link_on_ff)
   // every accepted request produces a response
   `ASSERT_IMPLIES(a_fire_rsp, clock, reset, req_fire, ##1 rsp_valid_ff)
   // idle status shows a steady led
   `ASSERT_HOLDS(a_steady_led, clock, reset, !(rsp_valid_ff && rsp_data_ff.link_up && !rsp_data_ff.laser_out && !rsp_data_ff.trigger_out) || rsp_data_ff.led_out)

endmodule

// File: sim/tb_pan_tilt_slew_controller.sv
// self-checking testbench for the pan/tilt slew controller, with random handshakes
`timescale 1ns / 100ps

module tb_pan_tilt_slew_controller;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 200;
   // narrow timers so that saturation is reached within a short run
   localparam int TIME_BITS = 8;
   localparam logic [15:0] TIME_MAX = 16'((1 << TIME_BITS) - 1);

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   pts_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   pts_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pts_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pts_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   pts_pkg::req_type pending_requests[$];
   pts_pkg::rsp_type due_status[$];
   pts_pkg::rsp_type oldest;
   bit      req_taken = 1'b0;
   bit      hold_go = 1'b0;
   bit      rsp_hold = 1'b0;
   int      send_gap_pct = 0;
   int      recv_gap_pct = 0;
   int      mismatches = 0;
   int      quiet_cycles = 0;

   // mirrored controller state
   pts_pkg::cfg_type settings;
   logic [8:0]  pan_pos, pan_goal;
   logic [7:0]  tilt_pos, tilt_goal;
   logic        trigger_lvl, laser_lvl, link_lvl, blink_phase, led_lvl;
   logic [15:0] laser_ms, link_ms, slew_ms, blink_ms;

   pan_tilt_slew_controller #(
      .TIME_BITS (TIME_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v >= TIME_MAX) ? TIME_MAX : v + 16'd1;
   endfunction

   function automatic logic [8:0] limit_angle(input logic [15:0] word,
                                              input logic [8:0] ceiling);
      if (word[15]) return 9'd0;
      if (word > {7'd0, ceiling}) return ceiling;
      return word[8:0];
   endfunction

   function automatic logic [8:0] step_toward(input logic [8:0] pos, input logic [8:0] goal);
      if (pos < goal) return pos + 9'd1;
      if (pos > goal) return pos - 9'd1;
      return pos;
   endfunction

   function automatic void toggle_led(input logic [15:0] period);
      if (blink_ms >= period) begin
         blink_phase = !blink_phase;
         led_lvl = blink_phase;
         blink_ms = '0;
      end
   endfunction

   function automatic pts_pkg::rsp_type advance_mount(input pts_pkg::req_type r);
      pts_pkg::rsp_type s;
      if (r.kind == pts_pkg::KIND_TICK) begin
         laser_ms = bump(laser_ms);
         link_ms = bump(link_ms);
         slew_ms = bump(slew_ms);
         blink_ms = bump(blink_ms);
      end else begin
         pan_goal = limit_angle(r.pan_request, settings.pan_limit);
         tilt_goal = 8'(limit_angle(r.tilt_request, {1'b0, settings.tilt_limit}));
         link_ms = '0;
         link_lvl = 1'b1;
         if (r.trigger_code == pts_pkg::TRIGGER_ON) begin
            trigger_lvl = 1'b1;
         end else if (r.trigger_code == pts_pkg::TRIGGER_OFF) begin
            trigger_lvl = 1'b0;
         end
         if (r.trigger_code == pts_pkg::TRIGGER_FIRE && !laser_lvl) begin
            laser_lvl = 1'b1;
            laser_ms = '0;
         end
      end
      if (link_lvl && link_ms > settings.link_timeout_ms) link_lvl = 1'b0;
      if (slew_ms >= {8'd0, settings.slew_interval_ms}) begin
         pan_pos = step_toward(pan_pos, pan_goal);
         tilt_pos = 8'(step_toward({1'b0, tilt_pos}, {1'b0, tilt_goal}));
         slew_ms = '0;
      end
      if (laser_lvl && laser_ms >= settings.laser_pulse_ms) laser_lvl = 1'b0;
      if (laser_lvl) begin
         toggle_led(settings.blink_laser_ms);
      end else if (!link_lvl) begin
         toggle_led(settings.blink_nolink_ms);
      end else if (trigger_lvl) begin
         toggle_led(settings.blink_trigger_ms);
      end else begin
         led_lvl = 1'b1;
      end
      s.pan_now = pan_pos;
      s.tilt_now = tilt_pos;
      s.trigger_out = trigger_lvl;
      s.laser_out = laser_lvl;
      s.led_out = led_lvl;
      s.link_up = link_lvl;
      return s;
   endfunction

   function automatic pts_pkg::req_type tick_request();
      pts_pkg::req_type r;
      r.kind = pts_pkg::KIND_TICK;
      r.pan_request = 16'($urandom);
      r.tilt_request = 16'($urandom);
      r.trigger_code = 8'($urandom);
      return r;
   endfunction

   function automatic pts_pkg::req_type command_request(input logic [15:0] pan_word,
                                                        input logic [15:0] tilt_word,
                                                        input logic [7:0] code);
      pts_pkg::req_type r;
      r.kind = pts_pkg::KIND_COMMAND;
      r.pan_request = pan_word;
      r.tilt_request = tilt_word;
      r.trigger_code = code;
      return r;
   endfunction

   function automatic pts_pkg::cfg_type random_settings();
      pts_pkg::cfg_type s;
      s.link_timeout_ms = 16'($urandom_range(0, 40));
      s.laser_pulse_ms = 16'($urandom_range(0, 30));
      s.slew_interval_ms = 8'($urandom_range(0, 5));
      s.pan_limit = 9'($urandom_range(0, 511));
      s.tilt_limit = 8'($urandom_range(0, 255));
      s.blink_laser_ms = 16'($urandom_range(0, 8));
      s.blink_nolink_ms = 16'($urandom_range(0, 12));
      s.blink_trigger_ms = 16'($urandom_range(0, 8));
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // narrow registers get junk in the unused upper bits
   task automatic load_settings(input pts_pkg::cfg_type s);
      pts_pkg::reg_index_type idx;
      logic [15:0]            word;
      logic [7:0]             junk;
      idx = idx.first();
      repeat (8) begin
         junk = 8'($urandom);
         case (idx)
            pts_pkg::REG_LINK_TIMEOUT:  word = s.link_timeout_ms;
            pts_pkg::REG_LASER_PULSE:   word = s.laser_pulse_ms;
            pts_pkg::REG_SLEW_INTERVAL: word = {junk, s.slew_interval_ms};
            pts_pkg::REG_PAN_LIMIT:     word = {junk[6:0], s.pan_limit};
            pts_pkg::REG_TILT_LIMIT:    word = {junk, s.tilt_limit};
            pts_pkg::REG_BLINK_LASER:   word = s.blink_laser_ms;
            pts_pkg::REG_BLINK_NOLINK:  word = s.blink_nolink_ms;
            default:                    word = s.blink_trigger_ms;
         endcase
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= word;
         do @(posedge clock); while (!csr_ready);
         idx = idx.next();
      end
      settings = s;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_traffic(input int count);
      int          made;
      int          burst;
      int          k;
      logic [15:0] pan_word, tilt_word;
      logic [7:0]  code;
      made = 0;
      while (made < count) begin
         case ($urandom_range(0, 9))
            0:       pan_word = 16'($urandom);
            1:       pan_word = 16'(16'hFFFF - $urandom_range(0, 299));
            2:       pan_word = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: pan_word = 16'($urandom_range(0, 520));
         endcase
         case ($urandom_range(0, 9))
            0:       tilt_word = 16'($urandom);
            1:       tilt_word = 16'(16'hFFFF - $urandom_range(0, 299));
            2:       tilt_word = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: tilt_word = 16'($urandom_range(0, 270));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2: code = pts_pkg::TRIGGER_OFF;
            3, 4, 5: code = pts_pkg::TRIGGER_ON;
            6, 7:    code = pts_pkg::TRIGGER_FIRE;
            8:       code = 8'($urandom);
            default: code = 8'($urandom_range(3, 255));
         endcase
         pending_requests.push_back(command_request(pan_word, tilt_word, code));
         made++;
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 10);
         for (k = 0; k < burst && made < count; k++) begin
            pending_requests.push_back(tick_request());
            made++;
         end
      end
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || due_status.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            req_data <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // long receiver stall so the block backs up
   initial begin
      wait (hold_go);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // monitor: predict on each accepted request, check each response
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) due_status.push_back(advance_mount(req_data));
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_status.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest = due_status.pop_front();
            if (rsp_data.pan_now !== oldest.pan_now)
               report_mismatch($sformatf("pan_now %0d, wanted %0d",
                                         rsp_data.pan_now, oldest.pan_now));
            if (rsp_data.tilt_now !== oldest.tilt_now)
               report_mismatch($sformatf("tilt_now %0d, wanted %0d",
                                         rsp_data.tilt_now, oldest.tilt_now));
            if (rsp_data.trigger_out !== oldest.trigger_out)
               report_mismatch($sformatf("trigger_out %b, wanted %b",
                                         rsp_data.trigger_out, oldest.trigger_out));
            if (rsp_data.laser_out !== oldest.laser_out)
               report_mismatch($sformatf("laser_out %b, wanted %b",
                                         rsp_data.laser_out, oldest.laser_out));
            if (rsp_data.led_out !== oldest.led_out)
               report_mismatch($sformatf("led_out %b, wanted %b",
                                         rsp_data.led_out, oldest.led_out));
            if (rsp_data.link_up !== oldest.link_up)
               report_mismatch($sformatf("link_up %b, wanted %b",
                                         rsp_data.link_up, oldest.link_up));
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_pan_tilt_slew_controller failed");
      $finish;
   end

   initial begin
      pts_pkg::cfg_type plan;
      settings.link_timeout_ms = pts_pkg::RST_LINK_TIMEOUT;
      settings.laser_pulse_ms = pts_pkg::RST_LASER_PULSE;
      settings.slew_interval_ms = pts_pkg::RST_SLEW_INTERVAL;
      settings.pan_limit = pts_pkg::RST_PAN_LIMIT;
      settings.tilt_limit = pts_pkg::RST_TILT_LIMIT;
      settings.blink_laser_ms = pts_pkg::RST_BLINK_LASER;
      settings.blink_nolink_ms = pts_pkg::RST_BLINK_NOLINK;
      settings.blink_trigger_ms = pts_pkg::RST_BLINK_TRIGGER;
      pan_pos = pts_pkg::PAN_HOME;
      pan_goal = pts_pkg::PAN_HOME;
      tilt_pos = pts_pkg::TILT_HOME;
      tilt_goal = pts_pkg::TILT_HOME;
      trigger_lvl = 1'b0;
      laser_lvl = 1'b0;
      link_lvl = 1'b0;
      blink_phase = 1'b0;
      led_lvl = 1'b1;
      laser_ms = '0;
      link_ms = '0;
      slew_ms = '0;
      blink_ms = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 8;
      recv_gap_pct = 82;
      // reset settings in force
      pending_requests.push_back(tick_request());
      pending_requests.push_back(command_request(16'hFFFF, 16'h7FFF, pts_pkg::TRIGGER_ON));
      pending_requests.push_back(tick_request());
      pending_requests.push_back(tick_request());
      wait_quiet();

      plan = '{16'd2, 16'd3, 8'd1, 9'd511, 8'd255, 16'd1, 16'd2, 16'd1};
      load_settings(plan);
      pending_requests.push_back(command_request(16'h7FFF, 16'h8000, pts_pkg::TRIGGER_FIRE));
      // fire again while the pulse runs
      pending_requests.push_back(command_request(16'd0, 16'd0, pts_pkg::TRIGGER_FIRE));
      repeat (3) pending_requests.push_back(tick_request());
      pending_requests.push_back(command_request(16'd511, 16'd255, pts_pkg::TRIGGER_OFF));
      pending_requests.push_back(command_request(16'd512, 16'd256, 8'd3));
      pending_requests.push_back(command_request(16'h8000, 16'h7FFF, 8'd255));
      repeat (4) pending_requests.push_back(tick_request());
      pending_requests.push_back(command_request(16'd200, 16'hFFFF, pts_pkg::TRIGGER_ON));
      repeat (2) pending_requests.push_back(tick_request());
      pending_requests.push_back(command_request(16'd1, 16'd1, 8'd128));
      wait_quiet();

      // zero periods fire on every request, zero limits pin both axes
      load_settings('0);
      queue_traffic(80);
      wait_quiet();
      load_settings(random_settings());
      queue_traffic(150);
      wait_quiet();

      send_gap_pct = 82;
      recv_gap_pct = 8;
      repeat (2) begin
         load_settings(random_settings());
         queue_traffic(150);
         wait_quiet();
      end

      send_gap_pct = 0;
      recv_gap_pct = 0;
      load_settings(random_settings());
      hold_go = 1'b1;
      queue_traffic(200);
      wait_quiet();

      // every register at its top value, run the timers into saturation
      load_settings('1);
      pending_requests.push_back(command_request(16'd300, 16'd200, pts_pkg::TRIGGER_FIRE));
      repeat (300) pending_requests.push_back(tick_request());
      queue_traffic(30);
      wait_quiet();

      plan = '{16'd1, 16'd1, 8'd1, 9'd511, 8'd255, 16'd1, 16'd1, 16'd1};
      load_settings(plan);
      queue_traffic(60);
      wait_quiet();

      if (mismatches == 0) begin
         $display("tb_pan_tilt_slew_controller passed");
      end else begin
         $display("tb_pan_tilt_slew_controller failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_csr.sv
rtl/pan_tilt_slew_controller.sv
sim/tb_pan_tilt_slew_controller.sv
